// File: sv/bre_pkg.sv
// Shared types, constants and bit-search functions of the bitmap range engine.
`timescale 1ns / 1ps
package bre_pkg;

   localparam int DEFAULT_CAPACITY_BITS = 1024;
   localparam int WORD_BITS             = 64;
   localparam int WORD_SHIFT            = 6;

   localparam logic [3:0] OP_SET      = 4'd0;
   localparam logic [3:0] OP_FLIP     = 4'd1;
   localparam logic [3:0] OP_HAS      = 4'd2;
   localparam logic [3:0] OP_FIRST    = 4'd3;
   localparam logic [3:0] OP_LAST     = 4'd4;
   localparam logic [3:0] OP_COUNT    = 4'd5;
   localparam logic [3:0] OP_LEADING  = 4'd6;
   localparam logic [3:0] OP_TRAILING = 4'd7;
   localparam logic [3:0] OP_RESIZE   = 4'd8;
   localparam logic [3:0] OP_APPEND   = 4'd9;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;   // write one zero word during the post-reset sweep
      logic load;    // capture a new item
      logic read;    // read the word under the cursor
      logic step;    // process the word read last cycle
      logic finish;  // move the result into the output register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;  // cursor is on the last word of the sweep
      logic empty;       // loaded item touches no word
      logic last;        // word being processed ends the item
   } dp_status_type;

   // Index of the lowest set bit, found by halving in six steps.
   function automatic logic [5:0] low_index(input logic [63:0] v);
      logic [63:0] t;
      logic [5:0]  r;
      t = v;
      r = 6'd0;
      for (int k = 5; k >= 0; k--) begin
         if ((t & ((64'd1 << (1 << k)) - 64'd1)) == 64'd0) begin
            r[k] = 1'b1;
            t    = t >> (1 << k);
         end
      end
      return r;
   endfunction

   // Index of the highest set bit, found by halving in six steps.
   function automatic logic [5:0] high_index(input logic [63:0] v);
      logic [63:0] t;
      logic [5:0]  r;
      t = v;
      r = 6'd0;
      for (int k = 5; k >= 0; k--) begin
         if ((t >> (1 << k)) != 64'd0) begin
            r[k] = 1'b1;
            t    = t >> (1 << k);
         end
      end
      return r;
   endfunction

   // Number of set bits in one word, summed as a balanced adder tree.
   function automatic logic [6:0] pop_count(input logic [63:0] v);
      logic [1:0] s1 [32];
      logic [2:0] s2 [16];
      logic [3:0] s3 [8];
      logic [4:0] s4 [4];
      logic [5:0] s5 [2];
      for (int k = 0; k < 32; k++) begin
         s1[k] = {1'b0, v[2*k]} + {1'b0, v[2*k+1]};
      end
      for (int k = 0; k < 16; k++) begin
         s2[k] = {1'b0, s1[2*k]} + {1'b0, s1[2*k+1]};
      end
      for (int k = 0; k < 8; k++) begin
         s3[k] = {1'b0, s2[2*k]} + {1'b0, s2[2*k+1]};
      end
      for (int k = 0; k < 4; k++) begin
         s4[k] = {1'b0, s3[2*k]} + {1'b0, s3[2*k+1]};
      end
      for (int k = 0; k < 2; k++) begin
         s5[k] = {1'b0, s4[2*k]} + {1'b0, s4[2*k+1]};
      end
      return {1'b0, s5[0]} + {1'b0, s5[1]};
   endfunction

endpackage

// File: sv/bre_ctrl.sv
// Controller state machine of the bitmap range engine.
`timescale 1ns / 1ps
module bre_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bre_pkg::dp_cmd_type    cmd,
   input  bre_pkg::dp_status_type status
);
   import bre_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_PROC,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      cmd.clear  = (state_ff == ST_CLEAR);
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.read   = (state_ff == ST_READ) && !status.empty;
      cmd.step   = (state_ff == ST_PROC);
      cmd.finish = (state_ff == ST_FINISH) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new result replaces the one leaving in the same cycle.
         if ((state_ff == ST_FINISH) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= status.empty ? ST_FINISH : ST_PROC;
            end
            ST_PROC: begin
               state_ff <= status.last ? ST_FINISH : ST_READ;
            end
            ST_FINISH: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// File: sv/bre_datapath.sv
// Datapath of the bitmap range engine: word store, length, range cursor and result.
`timescale 1ns / 1ps
module bre_datapath #(
   parameter int CAPACITY_BITS = bre_pkg::DEFAULT_CAPACITY_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bre_pkg::dp_cmd_type    cmd,
   output bre_pkg::dp_status_type status,
   input  logic [3:0]             req_opcode,
   input  logic [10:0]            req_range_start,
   input  logic [10:0]            req_range_length,
   input  logic                   req_bit_value,
   output logic [10:0]            rsp_answer,
   output logic                   rsp_found,
   output logic                   rsp_refused
);
   import bre_pkg::*;

   localparam int LEN_W     = $clog2(CAPACITY_BITS + 1);
   localparam int PW        = ((LEN_W > 11) ? LEN_W : 11) + 1;
   localparam int NUM_WORDS = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

   typedef enum logic [3:0] {
      M_NONE, M_SET, M_FLIP, M_HAS, M_FIRST, M_LAST, M_COUNT, M_LEAD, M_TRAIL
   } mode_type;

   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [WORD_BITS-1:0] rdata_ff;

   logic [LEN_W-1:0] len_ff;
   mode_type         mode_ff;
   logic             val_ff;
   logic [PW-1:0]    lo_ff, hi_ff, acc_ff;
   logic [AW-1:0]    w_ff, wend_ff;
   logic             empty_ff, found_ff, refused_ff;
   logic [10:0]      rsp_answer_ff;
   logic             rsp_found_ff, rsp_refused_ff;

   // Load decode.
   logic [PW-1:0] start_x, rlen_x, len_x, cap_x, room, n;
   logic [PW-1:0] lo_n, hi_n, hi_last_n;
   mode_type      mode_n;
   logic          val_n, empty_n, refused_n, len_we;
   logic [PW-1:0] len_n;
   logic          desc_n;

   always_comb begin
      start_x   = PW'(req_range_start);
      rlen_x    = PW'(req_range_length);
      len_x     = PW'(len_ff);
      cap_x     = PW'(CAPACITY_BITS);
      room      = len_x - start_x;
      n         = (start_x >= len_x) ? '0 : ((rlen_x < room) ? rlen_x : room);
      lo_n      = start_x;
      hi_n      = start_x + n;
      mode_n    = M_NONE;
      val_n     = req_bit_value;
      empty_n   = (n == '0);
      refused_n = 1'b0;
      len_we    = 1'b0;
      len_n     = len_x;
      case (req_opcode)
         OP_SET:   mode_n = M_SET;
         OP_FLIP:  mode_n = M_FLIP;
         OP_HAS:   mode_n = M_HAS;
         OP_FIRST: mode_n = M_FIRST;
         OP_LAST:  mode_n = M_LAST;
         OP_COUNT: mode_n = M_COUNT;
         OP_LEADING, OP_TRAILING: begin
            mode_n  = (req_opcode == OP_LEADING) ? M_LEAD : M_TRAIL;
            lo_n    = '0;
            hi_n    = len_x;
            empty_n = (len_x == '0);
         end
         OP_RESIZE: begin
            if (start_x > cap_x) begin
               refused_n = 1'b1;
               empty_n   = 1'b1;
            end else begin
               // Shrinking clears the dropped tail with a zero fill.
               mode_n  = M_SET;
               val_n   = 1'b0;
               hi_n    = len_x;
               empty_n = (start_x >= len_x);
               len_we  = 1'b1;
               len_n   = start_x;
            end
         end
         OP_APPEND: begin
            if (len_x >= cap_x) begin
               refused_n = 1'b1;
               empty_n   = 1'b1;
            end else begin
               mode_n  = M_SET;
               lo_n    = len_x;
               hi_n    = len_x + PW'(1);
               empty_n = 1'b0;
               len_we  = 1'b1;
               len_n   = len_x + PW'(1);
            end
         end
         default: begin
            empty_n = 1'b1;
         end
      endcase
      hi_last_n = hi_n - PW'(1);
      desc_n    = (mode_n == M_LAST) || (mode_n == M_TRAIL);
   end

   // Word processing.
   logic [PW-1:0]        hi_last, base;
   logic [AW-1:0]        lo_word, hi_word;
   logic [6:0]           a7, b7;
   logic [WORD_BITS-1:0] mask, match, miss, wdata;
   logic [5:0]           m_low, m_high, x_low, x_high;
   logic                 stop, desc, wr_mode;
   logic [PW-1:0]        acc_n;

   always_comb begin
      hi_last = hi_ff - PW'(1);
      lo_word = AW'(lo_ff >> WORD_SHIFT);
      hi_word = AW'(hi_last >> WORD_SHIFT);
      base    = PW'(w_ff) << WORD_SHIFT;
      a7      = (w_ff == lo_word) ? {1'b0, lo_ff[5:0]} : 7'd0;
      b7      = (w_ff == hi_word) ? ({1'b0, hi_last[5:0]} + 7'd1) : 7'd64;
      mask    = (~64'd0 << a7[5:0]) &
                (b7[6] ? ~64'd0 : ((64'd1 << b7[5:0]) - 64'd1));
      match   = (val_ff ? rdata_ff : ~rdata_ff) & mask;
      miss    = (val_ff ? ~rdata_ff : rdata_ff) & mask;
      m_low   = low_index(match);
      m_high  = high_index(match);
      x_low   = low_index(miss);
      x_high  = high_index(miss);
      desc    = (mode_ff == M_LAST) || (mode_ff == M_TRAIL);
      wr_mode = (mode_ff == M_SET) || (mode_ff == M_FLIP);
      wdata   = (mode_ff == M_FLIP) ? (rdata_ff ^ mask)
                                    : ((rdata_ff & ~mask) | (val_ff ? mask : 64'd0));
      stop    = 1'b0;
      acc_n   = acc_ff;
      case (mode_ff)
         M_HAS: begin
            stop = (match != 64'd0);
         end
         M_FIRST: begin
            stop  = (match != 64'd0);
            acc_n = base + PW'(m_low);
         end
         M_LAST: begin
            stop  = (match != 64'd0);
            acc_n = base + PW'(m_high);
         end
         M_COUNT: begin
            acc_n = acc_ff + PW'(pop_count(match));
         end
         M_LEAD: begin
            stop  = (miss != 64'd0);
            acc_n = stop ? (acc_ff + PW'(x_low) - PW'(a7))
                         : (acc_ff + PW'(b7) - PW'(a7));
         end
         M_TRAIL: begin
            stop  = (miss != 64'd0);
            acc_n = stop ? (acc_ff + PW'(b7) - PW'(1) - PW'(x_high))
                         : (acc_ff + PW'(b7) - PW'(a7));
         end
         default: begin
            stop = 1'b0;
         end
      endcase
   end

   always_comb begin
      status            = '0;
      status.clear_last = (w_ff == AW'(NUM_WORDS - 1));
      status.empty      = empty_ff;
      status.last       = stop || (w_ff == wend_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[w_ff] <= '0;
      end else if (cmd.step && wr_mode) begin
         mem[w_ff] <= wdata;
      end
      if (cmd.read) begin
         rdata_ff <= mem[w_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         w_ff   <= '0;
      end else begin
         if (cmd.clear) begin
            w_ff <= w_ff + AW'(1);
         end else if (cmd.load) begin
            w_ff <= desc_n ? AW'(hi_last_n >> WORD_SHIFT) : AW'(lo_n >> WORD_SHIFT);
            if (len_we) begin
               len_ff <= LEN_W'(len_n);
            end
         end else if (cmd.step) begin
            w_ff <= desc ? (w_ff - AW'(1)) : (w_ff + AW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= mode_n;
         val_ff     <= val_n;
         lo_ff      <= lo_n;
         hi_ff      <= hi_n;
         wend_ff    <= desc_n ? AW'(lo_n >> WORD_SHIFT) : AW'(hi_last_n >> WORD_SHIFT);
         empty_ff   <= empty_n;
         refused_ff <= refused_n;
         acc_ff     <= '0;
         found_ff   <= 1'b0;
      end else if (cmd.step) begin
         if ((mode_ff == M_HAS) || (mode_ff == M_FIRST) || (mode_ff == M_LAST)) begin
            if (stop) begin
               found_ff <= 1'b1;
               if (mode_ff != M_HAS) begin
                  acc_ff <= acc_n;
               end
            end
         end else begin
            acc_ff <= acc_n;
         end
      end
      if (cmd.finish) begin
         rsp_answer_ff  <= acc_ff[10:0];
         rsp_found_ff   <= found_ff;
         rsp_refused_ff <= refused_ff;
      end
   end

   assign rsp_answer  = rsp_answer_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_refused = rsp_refused_ff;

endmodule

// File: sv/bitmap_range_engine_core.sv
// Top level of the bitmap range engine: controller plus word-wide datapath.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake              Payload
//  req_      in         req_valid / req_stall  opcode, range_start, range_length, bit_value
//  rsp_      out        rsp_valid / rsp_stall  answer, found, refused
//
// The store is kept as 64-bit words in a single memory with a registered read
// port. Every range operation walks the words it touches, reading each word and then
// processing it and writing it back. An item moves from the accept through the
// word walk to the finish step, and no new item is taken before that; an empty
// range skips the walk. The finish step moves the result into the output register.
// Searches stop early at the first word that holds a match.
// After reset a clearing pass writes zero to all CAPACITY_BITS / 64 words, rounded
// up, while req_stall stays high.
// A finished result sits in the output register; a new item is taken while it
// waits, and the next result holds back until the register is free.
module bitmap_range_engine_core #(
   parameter int CAPACITY_BITS = bre_pkg::DEFAULT_CAPACITY_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_opcode,
   input  logic [10:0] req_range_start,
   input  logic [10:0] req_range_length,
   input  logic        req_bit_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_answer,
   output logic        rsp_found,
   output logic        rsp_refused
);
   import bre_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller sequences the clearing pass and the word walk.
   bre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the store, the length and the running result.
   bre_datapath #(
      .CAPACITY_BITS (CAPACITY_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_range_start  (req_range_start),
      .req_range_length (req_range_length),
      .req_bit_value    (req_bit_value),
      .rsp_answer       (rsp_answer),
      .rsp_found        (rsp_found),
      .rsp_refused      (rsp_refused)
   );

   // Coming out of reset the block is busy clearing and holds no result.
   a_reset_quiet: assert property (@(posedge clock) reset |=> req_stall && !rsp_valid)
      else $error("block not quiet after reset");

   // An accepted item keeps the block busy on the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again right after an accept");

   // A refused item never reports a match.
   a_refused_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_refused))
      else $error("result both found and refused");

endmodule

// File: bench/bitmap_range_engine_core_tb.sv
// Self-checking testbench for the bitmap range engine core.
`timescale 1ns / 1ps
module bitmap_range_engine_core_tb;
   import bre_pkg::*;

   localparam int CAP = 1024;

   // Opcodes without an operation.
   localparam logic [3:0] OP_SPARE_FIRST = 4'd10;
   localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [10:0] start;
      logic [10:0] len;
      logic        value;
   } item_type;

   typedef struct packed {
      logic [10:0] answer;
      logic        found;
      logic        refused;
   } outcome_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [3:0]  req_opcode;
   logic [10:0] req_range_start;
   logic [10:0] req_range_length;
   logic        req_bit_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [10:0] rsp_answer;
   logic        rsp_found;
   logic        rsp_refused;

   item_type    pending_items[$];
   outcome_type expected_outcomes[$];
   logic        store_bits[CAP] = '{default: 1'b0};
   int          store_length = 0;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          error_count = 0;

   bitmap_range_engine_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Predicts one outcome for an operation and updates the bit store copy.
   function automatic outcome_type apply_operation(item_type it);
      outcome_type o;
      int n;
      int s;
      int cnt;
      o = '0;
      s = int'(it.start);
      n = 0;
      cnt = 0;
      if (s < store_length) begin
         n = store_length - s;
         if (int'(it.len) < n) n = int'(it.len);
      end
      case (it.opcode)
         OP_SET, OP_FLIP: begin
            for (int i = 0; i < n; i++)
               store_bits[s + i] = (it.opcode == OP_SET) ? it.value : ~store_bits[s + i];
         end
         OP_HAS, OP_FIRST: begin
            for (int i = 0; i < n; i++) begin
               if (store_bits[s + i] == it.value) begin
                  o.found = 1'b1;
                  if (it.opcode == OP_FIRST) o.answer = 11'(s + i);
                  break;
               end
            end
         end
         OP_LAST: begin
            for (int i = n - 1; i >= 0; i--) begin
               if (store_bits[s + i] == it.value) begin
                  o.found = 1'b1;
                  o.answer = 11'(s + i);
                  break;
               end
            end
         end
         OP_COUNT: begin
            for (int i = 0; i < n; i++)
               if (store_bits[s + i] == it.value) cnt++;
            o.answer = 11'(cnt);
         end
         OP_LEADING: begin
            for (int i = 0; i < store_length; i++) begin
               if (store_bits[i] != it.value) break;
               cnt++;
            end
            o.answer = 11'(cnt);
         end
         OP_TRAILING: begin
            for (int i = store_length - 1; i >= 0; i--) begin
               if (store_bits[i] != it.value) break;
               cnt++;
            end
            o.answer = 11'(cnt);
         end
         OP_RESIZE: begin
            if (s > CAP) begin
               o.refused = 1'b1;
            end else begin
               for (int i = s; i < store_length; i++) store_bits[i] = 1'b0;
               store_length = s;
            end
         end
         OP_APPEND: begin
            if (store_length >= CAP) begin
               o.refused = 1'b1;
            end else begin
               store_bits[store_length] = it.value;
               store_length++;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic item_type make_item(logic [3:0] op, int s, int l, logic v);
      item_type it;
      it.opcode = op;
      it.start = 11'(s);
      it.len = 11'(l);
      it.value = v;
      return it;
   endfunction

   // Random item; ranges mostly fall near the current length so they hit bits.
   function automatic item_type random_item(int model_len);
      item_type it;
      int r;
      r = $urandom_range(0, 99);
      it.value = 1'($urandom);
      it.start = 11'($urandom_range(0, model_len + 8));
      it.len = 11'($urandom_range(0, 80));
      if (r < 12) begin
         it.opcode = OP_APPEND;
      end else if (r < 16) begin
         it.opcode = OP_RESIZE;
         it.start = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 200));
      end else if (r < 19) begin
         it.opcode = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         it.start = 11'($urandom);
         it.len = 11'($urandom);
      end else begin
         it.opcode = 4'($urandom_range(OP_SET, OP_TRAILING));
         if ($urandom_range(0, 9) == 0) it.len = 11'($urandom);
         if ($urandom_range(0, 19) == 0) it.start = 11'($urandom);
      end
      return it;
   endfunction

   // Driver: presents queued items and predicts each one as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_opcode <= OP_SET;
         req_range_start <= '0;
         req_range_length <= '0;
         req_bit_value <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_outcomes.push_back(apply_operation({req_opcode, req_range_start,
                                                         req_range_length, req_bit_value}));
         if (!req_valid || !req_stall) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               item_type it;
               it = pending_items.pop_front();
               req_valid <= 1'b1;
               req_opcode <= it.opcode;
               req_range_start <= it.start;
               req_range_length <= it.len;
               req_bit_value <= it.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               $display("%0t: unexpected result answer=%0d found=%0d refused=%0d",
                        $time, rsp_answer, rsp_found, rsp_refused);
               error_count++;
            end else begin
               outcome_type e;
               e = expected_outcomes.pop_front();
               if (e.answer !== rsp_answer) begin
                  $display("%0t: answer expected %0d actual %0d", $time, e.answer, rsp_answer);
                  error_count++;
               end
               if (e.found !== rsp_found) begin
                  $display("%0t: found expected %0d actual %0d", $time, e.found, rsp_found);
                  error_count++;
               end
               if (e.refused !== rsp_refused) begin
                  $display("%0t: refused expected %0d actual %0d",
                           $time, e.refused, rsp_refused);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   initial begin
      #2000000;
      $display("bitmap_range_engine_core verification failed");
      $finish;
   end

   // Model length tracked while queuing, so random ranges stay relevant.
   int plan_len;

   task automatic plan(item_type it);
      pending_items.push_back(it);
      if (it.opcode == OP_APPEND && plan_len < CAP) plan_len++;
      if (it.opcode == OP_RESIZE && it.start <= CAP) plan_len = int'(it.start);
   endtask

   task automatic run_phase(int idle, int stall, int count);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < count; i++) plan(random_item(plan_len));
      while (pending_items.size() > 0 || req_valid || expected_outcomes.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      plan_len = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty store, growth, every operation, extremes, full store.
      plan(make_item(OP_FIRST, 0, 1024, 1'b0));
      plan(make_item(OP_APPEND, 0, 0, 1'b1));
      plan(make_item(OP_APPEND, 2047, 2047, 1'b0));
      plan(make_item(OP_RESIZE, 1025, 0, 1'b0));
      plan(make_item(OP_RESIZE, 2047, 0, 1'b1));
      plan(make_item(OP_RESIZE, 1024, 0, 1'b0));
      plan(make_item(OP_SET, 0, 1024, 1'b1));
      plan(make_item(OP_APPEND, 0, 0, 1'b1));
      plan(make_item(OP_COUNT, 0, 2047, 1'b1));
      plan(make_item(OP_LEADING, 5, 5, 1'b1));
      plan(make_item(OP_TRAILING, 0, 0, 1'b1));
      plan(make_item(OP_FLIP, 100, 300, 1'b0));
      plan(make_item(OP_FIRST, 0, 1024, 1'b0));
      plan(make_item(OP_LAST, 0, 1024, 1'b0));
      plan(make_item(OP_HAS, 1023, 2047, 1'b0));
      plan(make_item(OP_LAST, 2047, 10, 1'b1));
      plan(make_item(OP_SET, 1024, 5, 1'b1));
      plan(make_item(OP_FLIP, 63, 2, 1'b1));
      plan(make_item(OP_COUNT, 60, 10, 1'b0));
      plan(make_item(OP_SPARE_LAST, 2047, 2047, 1'b1));
      plan(make_item(OP_SPARE_FIRST, 0, 0, 1'b0));
      plan(make_item(OP_RESIZE, 70, 0, 1'b0));
      plan(make_item(OP_RESIZE, 200, 0, 1'b0));
      plan(make_item(OP_LEADING, 0, 0, 1'b0));
      plan(make_item(OP_TRAILING, 0, 0, 1'b0));
      run_phase(0, 0, 0);

      run_phase(0, 0, 500);
      run_phase(88, 0, 450);
      run_phase(0, 88, 450);
      run_phase(27, 27, 450);

      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("bitmap_range_engine_core verification clean");
      end else begin
         $display("bitmap_range_engine_core verification failed");
      end
      $finish;
   end

endmodule
